@@ sv/tile_mean_pixelation_macros.svh @@
// Assertion macros shared by the checker of the tile mean pixelation block.
`ifndef TILE_MEAN_PIXELATION_MACROS_SVH
`define TILE_MEAN_PIXELATION_MACROS_SVH

// Checked at every rising edge, switched off while reset is asserted.
`define TMPIX_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define TMPIX_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ sv/tmpix_pkg.sv @@
`timescale 1ns / 1ps
package tmpix_pkg;

    // Tile geometry and region limits.
    localparam int TILE         = 16;
    localparam int TILE_LOG2    = 4;
    localparam int MAX_WIDTH    = 2048;
    localparam int MAX_HEIGHT   = 2048;
    localparam int TILE_COLUMNS = MAX_WIDTH / TILE;
    localparam int COL_W        = 7;
    localparam int POS_W        = 11;
    localparam int DIM_W        = 12;
    localparam int SIDE_W       = 5;
    localparam int SUM_W        = 16;
    localparam int CNT_W        = 9;
    localparam int CHANNELS     = 3;

    // Job queue between the front and the back.
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = 2;

    // Register indexes of the configuration port.
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // One finished tile on its way to the divider.
    typedef struct packed {
        logic [COL_W-1:0]  tile_col;
        logic [COL_W-1:0]  tile_row;
        logic [SIDE_W-1:0] tile_width;
        logic [SIDE_W-1:0] tile_height;
        logic [SUM_W-1:0]  sum_blue;
        logic [SUM_W-1:0]  sum_green;
        logic [SUM_W-1:0]  sum_red;
        logic              frame_done;
    } t_tile_job;

    // A zero size counts as one, anything above the limit as the limit.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] hi);
        logic [DIM_W-1:0] res;
        begin
            if (v == '0) begin
                res = DIM_W'(1);
            end else if (v > hi) begin
                res = hi;
            end else begin
                res = v;
            end
            return res;
        end
    endfunction

endpackage

@@ sv/tmpix_if.sv @@
`timescale 1ns / 1ps
// Pixel channel: one item is one pixel.
interface tmpix_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    modport source (output valid, blue, green, red, input ready);
    modport sink (input valid, blue, green, red, output ready);
endinterface

// Tile result channel: one item is one finished tile.
interface tmpix_tile_if;
    logic       valid;
    logic       ready;
    logic [6:0] tile_col;
    logic [6:0] tile_row;
    logic [4:0] tile_width;
    logic [4:0] tile_height;
    logic [7:0] mean_blue;
    logic [7:0] mean_green;
    logic [7:0] mean_red;
    logic       frame_done;
    modport source (output valid, tile_col, tile_row, tile_width, tile_height,
                    mean_blue, mean_green, mean_red, frame_done, input ready);
    modport sink (input valid, tile_col, tile_row, tile_width, tile_height,
                  mean_blue, mean_green, mean_red, frame_done, output ready);
endinterface

@@ sv/tmpix_ram.sv @@
`timescale 1ns / 1ps
module tmpix_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port; a read sees the old data.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/tmpix_front.sv @@
`timescale 1ns / 1ps
module tmpix_front
    import tmpix_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_restart,
    input  logic [DIM_W-1:0]  i_width,
    input  logic [DIM_W-1:0]  i_height,
    tmpix_pix_if.sink         i_pix,
    input  logic [QPTR_W:0]   i_q_count,
    output logic              o_push,
    output t_tile_job         o_job
);

    localparam int RAM_W = CHANNELS * SUM_W;

    logic [POS_W-1:0]  r_col, n_col;
    logic [POS_W-1:0]  r_row, n_row;
    logic [POS_W-1:0]  col, row;
    logic [COL_W-1:0]  tc, tr;
    logic              last_col, last_row, first_px, emit, accept;
    logic [DIM_W-1:0]  tw_full, th_full;
    logic [SIDE_W-1:0] tw, th;

    logic              r_s1_valid;
    logic [COL_W-1:0]  r_s1_tc, r_s1_tr;
    logic [SIDE_W-1:0] r_s1_tw, r_s1_th;
    logic              r_s1_first, r_s1_emit, r_s1_done;
    logic [7:0]        r_s1_px [CHANNELS];

    logic              r_wr_valid;
    logic [COL_W-1:0]  r_wr_addr;
    logic [RAM_W-1:0]  r_wr_data;
    logic [RAM_W-1:0]  rdata, old_sums, new_sums;

    // Room is kept in the queue for the tile that may sit in the accumulate stage.
    assign i_pix.ready = ({1'b0, i_q_count} + {{(QPTR_W+1){1'b0}}, r_s1_valid})
                         < (QPTR_W + 2)'(QUEUE_DEPTH);
    assign accept = i_pix.valid && i_pix.ready;

    // Position of the incoming pixel and its place within the tile grid.
    always_comb begin
        col = ({1'b0, r_col} >= i_width)  ? '0 : r_col;
        row = ({1'b0, r_row} >= i_height) ? '0 : r_row;
        tc  = col[POS_W-1:TILE_LOG2];
        tr  = row[POS_W-1:TILE_LOG2];
        last_col = ({1'b0, col} == (i_width - DIM_W'(1)));
        last_row = ({1'b0, row} == (i_height - DIM_W'(1)));
        first_px = (col[TILE_LOG2-1:0] == '0) && (row[TILE_LOG2-1:0] == '0);
        emit = ((col[TILE_LOG2-1:0] == TILE_LOG2'(TILE - 1)) || last_col) &&
               ((row[TILE_LOG2-1:0] == TILE_LOG2'(TILE - 1)) || last_row);
        tw_full = i_width  - {1'b0, tc, {TILE_LOG2{1'b0}}};
        th_full = i_height - {1'b0, tr, {TILE_LOG2{1'b0}}};
        tw = (tw_full > DIM_W'(TILE)) ? SIDE_W'(TILE) : tw_full[SIDE_W-1:0];
        th = (th_full > DIM_W'(TILE)) ? SIDE_W'(TILE) : th_full[SIDE_W-1:0];
    end

    // Raster walk with wrap at the end of the region.
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_restart) begin
            n_col = '0;
            n_row = '0;
        end else if (accept) begin
            if (last_col) begin
                n_col = '0;
                n_row = last_row ? '0 : row + POS_W'(1);
            end else begin
                n_col = col + POS_W'(1);
                n_row = row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
            r_wr_valid <= 1'b0;
        end else begin
            r_col      <= n_col;
            r_row      <= n_row;
            r_s1_valid <= accept;
            r_wr_valid <= r_s1_valid;
        end
    end

    // Accumulate stage payload.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_tc    <= tc;
            r_s1_tr    <= tr;
            r_s1_tw    <= tw;
            r_s1_th    <= th;
            r_s1_first <= first_px;
            r_s1_emit  <= emit;
            r_s1_done  <= last_col && last_row;
            r_s1_px[0] <= i_pix.blue;
            r_s1_px[1] <= i_pix.green;
            r_s1_px[2] <= i_pix.red;
        end
        r_wr_addr <= r_s1_tc;
        r_wr_data <= new_sums;
    end

    // Column sums of the current band, read when a pixel is taken.
    tmpix_ram #(
        .WIDTH (RAM_W),
        .DEPTH (TILE_COLUMNS)
    ) u_sums (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_tc),
        .i_wdata (new_sums),
        .i_re    (accept),
        .i_raddr (tc),
        .o_rdata (rdata)
    );

    // The write of the pixel just before lands too late for the read, so it is forwarded.
    always_comb begin
        old_sums = (r_wr_valid && (r_wr_addr == r_s1_tc)) ? r_wr_data : rdata;
        for (int c = 0; c < CHANNELS; c++) begin
            if (r_s1_first) begin
                new_sums[c*SUM_W +: SUM_W] = {{(SUM_W-8){1'b0}}, r_s1_px[c]};
            end else begin
                new_sums[c*SUM_W +: SUM_W] = old_sums[c*SUM_W +: SUM_W] +
                                             {{(SUM_W-8){1'b0}}, r_s1_px[c]};
            end
        end
    end

    // A finished tile goes to the queue.
    assign o_push = r_s1_valid && r_s1_emit;
    always_comb begin
        o_job.tile_col    = r_s1_tc;
        o_job.tile_row    = r_s1_tr;
        o_job.tile_width  = r_s1_tw;
        o_job.tile_height = r_s1_th;
        o_job.sum_blue    = new_sums[0*SUM_W +: SUM_W];
        o_job.sum_green   = new_sums[1*SUM_W +: SUM_W];
        o_job.sum_red     = new_sums[2*SUM_W +: SUM_W];
        o_job.frame_done  = r_s1_done;
    end

endmodule

@@ sv/tmpix_queue.sv @@
`timescale 1ns / 1ps
module tmpix_queue
    import tmpix_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  t_tile_job       i_job,
    input  logic            i_pop,
    output t_tile_job       o_head,
    output logic            o_nonempty,
    output logic [QPTR_W:0] o_count
);

    t_tile_job         r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr, r_rptr;
    logic [QPTR_W:0]   r_count;

    // Pointers and fill level; the writer never pushes into a full queue.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + QPTR_W'(1);
            end
            r_count <= r_count + {{QPTR_W{1'b0}}, i_push} - {{QPTR_W{1'b0}}, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_job;
        end
    end

    assign o_head     = r_slot[r_rptr];
    assign o_nonempty = (r_count != '0);
    assign o_count    = r_count;

endmodule

@@ sv/tmpix_back.sv @@
`timescale 1ns / 1ps
module tmpix_back
    import tmpix_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_tile_job  i_head,
    input  logic       i_nonempty,
    output logic       o_pop,
    tmpix_tile_if.source o_tile
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]        r_state, n_state;
    logic [3:0]        r_step;
    t_tile_job         r_job;
    logic [CNT_W-1:0]  r_n;
    logic [SUM_W-1:0]  r_quo [CHANNELS];
    logic [CNT_W-1:0]  r_rem [CHANNELS];
    logic [SUM_W-1:0]  n_quo [CHANNELS];
    logic [CNT_W-1:0]  n_rem [CHANNELS];
    logic [CNT_W-1:0]  trial [CHANNELS];
    logic [7:0]        mean [CHANNELS];
    logic [CNT_W:0]    twice;
    logic [SUM_W:0]    rounded;
    logic              round_up;
    logic              out_free;

    logic              r_out_valid;
    t_tile_job         r_out_job;
    logic [7:0]        r_out_mean [CHANNELS];

    assign out_free = !r_out_valid || o_tile.ready;
    assign o_pop    = (r_state == ST_IDLE) && i_nonempty;

    // One restoring division step per cycle, three channels side by side.
    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            trial[c] = {r_rem[c][CNT_W-2:0], r_quo[c][SUM_W-1]};
            if (trial[c] >= r_n) begin
                n_rem[c] = trial[c] - r_n;
                n_quo[c] = {r_quo[c][SUM_W-2:0], 1'b1};
            end else begin
                n_rem[c] = trial[c];
                n_quo[c] = {r_quo[c][SUM_W-2:0], 1'b0};
            end
        end
    end

    // Round to nearest with ties to even, then saturate to eight bits.
    always_comb begin
        twice    = '0;
        rounded  = '0;
        round_up = 1'b0;
        for (int c = 0; c < CHANNELS; c++) begin
            twice    = {r_rem[c], 1'b0};
            round_up = (twice > {1'b0, r_n}) || ((twice == {1'b0, r_n}) && r_quo[c][0]);
            rounded  = {1'b0, r_quo[c]} + {{SUM_W{1'b0}}, round_up};
            mean[c]  = (rounded > (SUM_W+1)'(255)) ? 8'hFF : rounded[7:0];
        end
    end

    // Sequencer: load a tile, divide, hand over to the output register.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_nonempty) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (r_step == 4'd0) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_tile.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Division datapath.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job    <= i_head;
            r_n      <= {{(CNT_W-SIDE_W){1'b0}}, i_head.tile_width} *
                        {{(CNT_W-SIDE_W){1'b0}}, i_head.tile_height};
            r_step   <= 4'(SUM_W - 1);
            r_quo[0] <= i_head.sum_blue;
            r_quo[1] <= i_head.sum_green;
            r_quo[2] <= i_head.sum_red;
            for (int c = 0; c < CHANNELS; c++) begin
                r_rem[c] <= '0;
            end
        end else if (r_state == ST_DIV) begin
            r_step <= r_step - 4'd1;
            for (int c = 0; c < CHANNELS; c++) begin
                r_quo[c] <= n_quo[c];
                r_rem[c] <= n_rem[c];
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && out_free) begin
            r_out_job <= r_job;
            for (int c = 0; c < CHANNELS; c++) begin
                r_out_mean[c] <= mean[c];
            end
        end
    end

    assign o_tile.valid       = r_out_valid;
    assign o_tile.tile_col    = r_out_job.tile_col;
    assign o_tile.tile_row    = r_out_job.tile_row;
    assign o_tile.tile_width  = r_out_job.tile_width;
    assign o_tile.tile_height = r_out_job.tile_height;
    assign o_tile.mean_blue   = r_out_mean[0];
    assign o_tile.mean_green  = r_out_mean[1];
    assign o_tile.mean_red    = r_out_mean[2];
    assign o_tile.frame_done  = r_out_job.frame_done;

endmodule

@@ sv/tile_mean_pixelation.sv @@
`timescale 1ns / 1ps
// Tile mean pixelation.
// i_pix takes one pixel per item (blue, green, red) in raster order over a region
// of region_width x region_height pixels, both set on the APB port at byte
// addresses 0 and 4. A register write restarts the frame at the top-left pixel.
// The region is cut into 16 x 16 tiles, clipped at the right and bottom edges.
// When the last pixel of a tile is taken, o_tile carries one item: tile column
// and row, clipped size, rounded per-channel means and frame_done on the last tile.
// Pixels are taken one per cycle while i_pix.ready is high. Each finished tile goes through a 16-step
// divider, which takes the next tile from the queue only after the last one has
// passed to the output register.
// A four-entry tile queue absorbs bursts; i_pix.ready drops while the queue is
// full, or holds three tiles while a pixel is still in the accumulate stage.
// A stall on o_tile holds the result in the output register; the divider and
// the queue go on filling behind it until the queue is full.
// Reset empties the queue and the output, restarts the frame and sets both
// region registers to 2048. No clearing pass is needed: the first pixel of each
// tile overwrites its column's sums.
module tile_mean_pixelation
    import tmpix_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    tmpix_pix_if.sink   i_pix,
    tmpix_tile_if.source o_tile
);

    logic [DIM_W-1:0] r_region_width, r_region_height;
    logic [DIM_W-1:0] width_eff, height_eff;
    logic             cfg_wr;
    logic             push, pop, nonempty;
    t_tile_job        job, head;
    logic [QPTR_W:0]  q_count;

    // Configuration registers.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_region_width  <= DIM_W'(MAX_WIDTH);
            r_region_height <= DIM_W'(MAX_HEIGHT);
        end else if (cfg_wr) begin
            if (paddr[2] == REG_WIDTH) begin
                r_region_width <= pwdata[DIM_W-1:0];
            end else begin
                r_region_height <= pwdata[DIM_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_HEIGHT) ? {20'd0, r_region_height}
                                             : {20'd0, r_region_width};

    assign width_eff  = clamp_dim(r_region_width, DIM_W'(MAX_WIDTH));
    assign height_eff = clamp_dim(r_region_height, DIM_W'(MAX_HEIGHT));

    tmpix_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (cfg_wr),
        .i_width   (width_eff),
        .i_height  (height_eff),
        .i_pix     (i_pix),
        .i_q_count (q_count),
        .o_push    (push),
        .o_job     (job)
    );

    tmpix_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_job      (job),
        .i_pop      (pop),
        .o_head     (head),
        .o_nonempty (nonempty),
        .o_count    (q_count)
    );

    tmpix_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .i_nonempty (nonempty),
        .o_pop      (pop),
        .o_tile     (o_tile)
    );

endmodule

@@ sv/tmpix_checker.sv @@
`timescale 1ns / 1ps
`include "tile_mean_pixelation_macros.svh"
module tmpix_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_pready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [4:0] i_out_width,
    input logic [4:0] i_out_height,
    input logic [7:0] i_out_mean
);

    // A result waiting on the receiver stays put.
    `TMPIX_ASSERT(a_out_hold, i_out_valid && !i_out_ready |=> i_out_valid, "result dropped")
    `TMPIX_ASSERT(a_out_stable, i_out_valid && !i_out_ready |=> $stable(i_out_mean), "mean changed")
    // Nothing is offered in the cycle after reset.
    `TMPIX_ASSERT_ALWAYS(a_rst_empty, !i_rst_n |=> !i_out_valid, "result after reset")
    // Tile sizes are clipped to one tile and never zero.
    `TMPIX_ASSERT(a_size, i_out_valid |-> (i_out_width != 5'd0) && (i_out_width <= 5'd16) && (i_out_height != 5'd0) && (i_out_height <= 5'd16), "bad tile size")
    `TMPIX_ASSERT_ALWAYS(a_pready, i_pready, "pready low")

endmodule

bind tile_mean_pixelation tmpix_checker u_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_pready     (pready),
    .i_out_valid  (o_tile.valid),
    .i_out_ready  (o_tile.ready),
    .i_out_width  (o_tile.tile_width),
    .i_out_height (o_tile.tile_height),
    .i_out_mean   (o_tile.mean_blue)
);
